[hw/rtl/rtsc_pkg.sv]
// ----------------------------------------------------------------------------
// rtsc_pkg
// Shared constants, command/status structs and states for the ratio-test
// sigma-clipped centroid block.
// ----------------------------------------------------------------------------
package rtsc_pkg;

    localparam int MAX_CANDIDATES = 256;
    localparam int ADDR_W  = $clog2(MAX_CANDIDATES);
    localparam int CNT_W   = $clog2(MAX_CANDIDATES + 1);
    localparam int POS_W   = 20;
    localparam int MAG_W   = 20;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = POS_W + ADDR_W + 1;
    localparam int ACC_W   = SQ_W + ADDR_W;
    localparam int DIV_W   = ACC_W;
    localparam int DIVC_W  = $clog2(DIV_W + 1);
    localparam int SQ_IT   = (ACC_W + 1) / 2;
    localparam int SD_W    = SQ_IT;
    localparam int SQC_W   = $clog2(SQ_IT + 1);
    localparam int RAD_W   = 2 * SQ_IT;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_W   = 16;
    localparam int SCALE_SHIFT = 12;

    localparam logic [CNT_W-1:0] SMALL_N = CNT_W'(3);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CANDIDATES);

    localparam logic [CFG_IDX_W-1:0] REG_RATIO_LIMIT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT  = CFG_IDX_W'(3);

    localparam logic [CFG_W-1:0] RATIO_RST = 16'd45875;
    localparam logic [CFG_W-1:0] SCALE_RST = 16'd4096;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CHECK,
        S_MEAN_WAIT,
        S_P1_START,
        S_P1_WAIT,
        S_VAR_WAIT,
        S_SQRT_WAIT,
        S_P2_START,
        S_P2_WAIT,
        S_RES_WAIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic accept_en;
        logic mean_start;
        logic mean_cap;
        logic scan_start;
        logic scan_p2;
        logic var_start;
        logic sqrt_start;
        logic res_start;
        logic res_cap;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_in;
        logic n_zero;
        logic n_small;
        logic lane_busy;
        logic scan_busy;
        logic out_busy;
    } ctrl_st_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              v1;
        logic              v2;
        logic              p2;
        logic              scan_clr;
        logic              set_clr;
        logic              mean_start;
        logic              mean_cap;
        logic              var_start;
        logic              sqrt_start;
        logic              res_start;
        logic              res_cap;
    } lane_cmd_t;

endpackage

[hw/rtl/ratio_test_sigma_clipped_centroid.sv]
// ----------------------------------------------------------------------------
// ratio_test_sigma_clipped_centroid
// Ratio-test match filter with a one-sigma clipped centroid per axis.
// ----------------------------------------------------------------------------
// channel  dir  handshake            word
// s_       in   s_valid / s_ready    one feature match
// m_       out  m_valid / m_ready    one position estimate per set
// cfg_     in   cfg_valid/cfg_ready  register index and 16-bit data
//
// Matches load one per cycle. After the last word of a set, input stalls
// for the final passes: n = 0 skips them and n <= 3 takes the mean only;
// otherwise they run the serial divider, the serial root and two store
// scans. A finished result sits in the output register while the next set
// loads; the next set's result waits for it to be taken. Reset clears control
// state and loads the config defaults; the store needs no clearing.
// ----------------------------------------------------------------------------
module ratio_test_sigma_clipped_centroid
    import rtsc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [15:0]          s_dist_best,
    input  logic [15:0]          s_dist_second,
    input  logic [15:0]          s_obj_x,
    input  logic [15:0]          s_obj_y,
    input  logic [17:0]          s_scene_x,
    input  logic [17:0]          s_scene_y,
    input  logic                 s_last,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [19:0]   m_pos_x,
    output logic signed [19:0]   m_pos_y,
    output logic                 m_valid_res,
    output logic [8:0]           m_good_count,
    output logic                 m_overflow,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    ctrl_cmd_t cmd;
    ctrl_st_t  st;

    rtsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .st      (st),
        .cmd     (cmd)
    );

    rtsc_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .st            (st),
        .s_valid       (s_valid),
        .s_dist_best   (s_dist_best),
        .s_dist_second (s_dist_second),
        .s_obj_x       (s_obj_x),
        .s_obj_y       (s_obj_y),
        .s_scene_x     (s_scene_x),
        .s_scene_y     (s_scene_y),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pos_x       (m_pos_x),
        .m_pos_y       (m_pos_y),
        .m_valid_res   (m_valid_res),
        .m_good_count  (m_good_count),
        .m_overflow    (m_overflow),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    assign s_ready   = cmd.accept_en;
    assign cfg_ready = 1'b1;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_good_count <= 9'(MAX_CANDIDATES))
        else $error("good_count above store depth");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_pos_x == '0 && m_pos_y == '0)
        else $error("empty set gave a nonzero position");

    a_valid_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_valid_res == (m_good_count != '0))
        else $error("valid_res disagrees with good_count");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_good_count == 9'(MAX_CANDIDATES))
        else $error("overflow flagged with store not full");

endmodule

[hw/rtl/rtsc_div.sv]
// ----------------------------------------------------------------------------
// rtsc_div
// Iterative unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rtsc_div
    import rtsc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             busy,
    output logic [DIV_W-1:0] quot,
    output logic             rem_nz
);

    logic [DIV_W-1:0]  q_reg;
    logic [CNT_W:0]    r_reg;
    logic [CNT_W-1:0]  d_reg;
    logic [DIVC_W-1:0] cnt_reg;
    logic              busy_reg;
    logic [CNT_W:0]    r_sh;
    logic              take;

    assign r_sh = {r_reg[CNT_W-1:0], q_reg[DIV_W-1]};
    assign take = r_sh >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIVC_W'(DIV_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - DIVC_W'(1);
            if (cnt_reg == DIVC_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            r_reg <= take ? (r_sh - {1'b0, d_reg}) : r_sh;
            q_reg <= {q_reg[DIV_W-2:0], take};
        end
    end

    assign busy   = busy_reg;
    assign quot   = q_reg;
    assign rem_nz = r_reg != '0;

endmodule

[hw/rtl/rtsc_lane.sv]
// ----------------------------------------------------------------------------
// rtsc_lane
// One axis: candidate math, candidate store, sums, deviation pass, square
// root and clipped mean.
// ----------------------------------------------------------------------------
module rtsc_lane
    import rtsc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lane_cmd_t               lcmd,
    input  logic [CNT_W-1:0]        cnt,
    input  logic [CFG_W-1:0]        scale,
    input  logic [CFG_W-1:0]        half,
    input  logic [15:0]             obj,
    input  logic [17:0]             scene,
    output logic                    busy,
    output logic signed [POS_W-1:0] res
);

    logic signed [POS_W-1:0] mem [MAX_CANDIDATES];

    logic signed [16:0]      diff;
    logic signed [33:0]      prod;
    logic signed [22:0]      cand_w;
    logic signed [POS_W-1:0] cand;

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] ksum_reg;
    logic [CNT_W-1:0]        kcnt_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic signed [POS_W-1:0] mean_reg;
    logic signed [POS_W-1:0] res_reg;
    logic signed [POS_W-1:0] rd_reg;
    logic signed [POS_W-1:0] val_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic                    keep_reg;
    logic                    neg_reg;

    logic signed [POS_W:0]   d;
    logic [MAG_W-1:0]        mag;

    logic                    div_start;
    logic [DIV_W-1:0]        dividend;
    logic [CNT_W-1:0]        divisor;
    logic                    div_busy;
    logic [DIV_W-1:0]        quot;
    logic                    rem_nz;
    logic [POS_W:0]          q_mag;
    logic [POS_W:0]          q_fix;

    logic [RAD_W-1:0]        rad_reg;
    logic [SD_W-1:0]         root_reg;
    logic [SD_W+1:0]         rem_reg;
    logic [SQC_W-1:0]        sqc_reg;
    logic                    sq_busy_reg;
    logic [SD_W+1:0]         rem_sh;
    logic [SD_W+1:0]         trial;

    // candidate = floor((half - obj) * scale / 4096) + scene, saturated
    assign diff   = $signed({1'b0, half}) - $signed({1'b0, obj});
    assign prod   = diff * $signed({1'b0, scale});
    assign cand_w = 23'($signed(prod[33:SCALE_SHIFT])) + $signed({5'b0, scene});

    always_comb begin
        if (cand_w < -23'sd524288) begin
            cand = -20'sd524288;
        end else if (cand_w > 23'sd524287) begin
            cand = 20'sd524287;
        end else begin
            cand = cand_w[POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (lcmd.wr_en) begin
            mem[lcmd.wr_addr] <= cand;
        end
        if (lcmd.rd_en) begin
            rd_reg <= mem[lcmd.rd_addr];
        end
    end

    assign d   = {rd_reg[POS_W-1], rd_reg} - {mean_reg[POS_W-1], mean_reg};
    assign mag = d[POS_W] ? MAG_W'(-d) : MAG_W'(d);

    always_ff @(posedge aclk) begin
        if (lcmd.v1) begin
            sq_reg   <= mag * mag;
            keep_reg <= SD_W'(mag) < root_reg;
            val_reg  <= rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || lcmd.set_clr) begin
            sum_reg <= '0;
        end else if (lcmd.wr_en) begin
            sum_reg <= sum_reg + SUM_W'(cand);
        end
    end

    always_ff @(posedge aclk) begin
        if (lcmd.scan_clr) begin
            acc_reg  <= '0;
            ksum_reg <= '0;
            kcnt_reg <= '0;
        end else if (lcmd.v2) begin
            if (!lcmd.p2) begin
                acc_reg <= acc_reg + ACC_W'(sq_reg);
            end else if (keep_reg) begin
                ksum_reg <= ksum_reg + SUM_W'(val_reg);
                kcnt_reg <= kcnt_reg + CNT_W'(1);
            end
        end
    end

    always_comb begin
        div_start = lcmd.mean_start || lcmd.var_start ||
                    (lcmd.res_start && kcnt_reg != '0);
        dividend  = DIV_W'(sum_reg[SUM_W-1] ? -sum_reg : sum_reg);
        divisor   = cnt;
        if (lcmd.var_start) begin
            dividend = acc_reg;
            divisor  = cnt - CNT_W'(1);
        end else if (lcmd.res_start) begin
            dividend = DIV_W'(ksum_reg[SUM_W-1] ? -ksum_reg : ksum_reg);
            divisor  = kcnt_reg;
        end
    end

    rtsc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .quot     (quot),
        .rem_nz   (rem_nz)
    );

    // floor division of a signed value from magnitude quotient
    assign q_mag = {1'b0, quot[POS_W-1:0]};
    assign q_fix = neg_reg ? ((~q_mag) + (POS_W+1)'(1) - (POS_W+1)'(rem_nz)) : q_mag;

    always_ff @(posedge aclk) begin
        if (lcmd.mean_start) begin
            neg_reg <= sum_reg[SUM_W-1];
        end else if (lcmd.var_start) begin
            neg_reg <= 1'b0;
        end else if (lcmd.res_start) begin
            neg_reg <= ksum_reg[SUM_W-1];
        end
        if (lcmd.mean_cap) begin
            mean_reg <= q_fix[POS_W-1:0];
            res_reg  <= q_fix[POS_W-1:0];
        end else if (lcmd.res_cap) begin
            res_reg <= (kcnt_reg == '0) ? mean_reg : q_fix[POS_W-1:0];
        end
    end

    // floor square root, two radicand bits per cycle
    assign rem_sh = {rem_reg[SD_W-1:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_busy_reg <= 1'b0;
            sqc_reg     <= '0;
        end else if (lcmd.sqrt_start) begin
            sq_busy_reg <= 1'b1;
            sqc_reg     <= SQC_W'(SQ_IT);
        end else if (sq_busy_reg) begin
            sqc_reg <= sqc_reg - SQC_W'(1);
            if (sqc_reg == SQC_W'(1)) begin
                sq_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (lcmd.sqrt_start) begin
            rad_reg  <= RAD_W'(quot);
            root_reg <= '0;
            rem_reg  <= '0;
        end else if (sq_busy_reg) begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[SD_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[SD_W-2:0], 1'b0};
            end
        end
    end

    assign busy = div_busy || sq_busy_reg;
    assign res  = res_reg;

endmodule

[hw/rtl/rtsc_dp.sv]
// ----------------------------------------------------------------------------
// rtsc_dp
// Datapath: config registers, input stage, ratio test, candidate count,
// store scan sequencing, two axis lanes and the result register.
// ----------------------------------------------------------------------------
module rtsc_dp
    import rtsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctrl_cmd_t             cmd,
    output ctrl_st_t              st,
    input  logic                  s_valid,
    input  logic [15:0]           s_dist_best,
    input  logic [15:0]           s_dist_second,
    input  logic [15:0]           s_obj_x,
    input  logic [15:0]           s_obj_y,
    input  logic [17:0]           s_scene_x,
    input  logic [17:0]           s_scene_y,
    input  logic                  s_last,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [19:0]    m_pos_x,
    output logic signed [19:0]    m_pos_y,
    output logic                  m_valid_res,
    output logic [8:0]            m_good_count,
    output logic                  m_overflow,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    logic [CFG_W-1:0] ratio_reg, scale_reg, hw_reg, hh_reg;

    logic        st_valid_reg;
    logic        st_last_reg;
    logic [15:0] st_best_reg, st_second_reg, st_ox_reg, st_oy_reg;
    logic [17:0] st_sx_reg, st_sy_reg;

    logic [CNT_W-1:0] count_reg;
    logic             dropped_reg;
    logic             pass;
    logic             wr_en;

    logic             scan_active_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             v1_reg, v2_reg, p2_reg;

    logic             m_valid_reg;
    logic signed [19:0] pos_x_reg, pos_y_reg;
    logic             valid_res_reg;
    logic [8:0]       good_count_reg;
    logic             overflow_reg;

    lane_cmd_t        lcmd;
    logic             busy_x, busy_y;
    logic signed [POS_W-1:0] res_x, res_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg <= RATIO_RST;
            scale_reg <= SCALE_RST;
            hw_reg    <= '0;
            hh_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_RATIO_LIMIT:  ratio_reg <= cfg_data;
                REG_SCALE_FACTOR: scale_reg <= cfg_data;
                REG_HALF_WIDTH:   hw_reg    <= cfg_data;
                REG_HALF_HEIGHT:  hh_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else begin
            st_valid_reg <= s_valid && cmd.accept_en;
        end
        if (s_valid && cmd.accept_en) begin
            st_last_reg   <= s_last;
            st_best_reg   <= s_dist_best;
            st_second_reg <= s_dist_second;
            st_ox_reg     <= s_obj_x;
            st_oy_reg     <= s_obj_y;
            st_sx_reg     <= s_scene_x;
            st_sy_reg     <= s_scene_y;
        end
    end

    assign pass  = {st_best_reg, 16'h0000} < (ratio_reg * st_second_reg);
    assign wr_en = st_valid_reg && pass && (count_reg != MAX_CNT);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.out_load) begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else if (st_valid_reg && pass) begin
            if (count_reg != MAX_CNT) begin
                count_reg <= count_reg + CNT_W'(1);
            end else begin
                dropped_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_active_reg <= 1'b0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
        end else begin
            v1_reg <= scan_active_reg;
            v2_reg <= v1_reg;
            if (cmd.scan_start) begin
                scan_active_reg <= 1'b1;
            end else if (scan_active_reg && idx_reg == count_reg - CNT_W'(1)) begin
                scan_active_reg <= 1'b0;
            end
        end
        if (cmd.scan_start) begin
            idx_reg <= '0;
            p2_reg  <= cmd.scan_p2;
        end else if (scan_active_reg) begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
    end

    always_comb begin
        lcmd.wr_en      = wr_en;
        lcmd.wr_addr    = count_reg[ADDR_W-1:0];
        lcmd.rd_en      = scan_active_reg;
        lcmd.rd_addr    = idx_reg[ADDR_W-1:0];
        lcmd.v1         = v1_reg;
        lcmd.v2         = v2_reg;
        lcmd.p2         = p2_reg;
        lcmd.scan_clr   = cmd.scan_start;
        lcmd.set_clr    = cmd.out_load;
        lcmd.mean_start = cmd.mean_start;
        lcmd.mean_cap   = cmd.mean_cap;
        lcmd.var_start  = cmd.var_start;
        lcmd.sqrt_start = cmd.sqrt_start;
        lcmd.res_start  = cmd.res_start;
        lcmd.res_cap    = cmd.res_cap;
    end

    rtsc_lane u_lane_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .lcmd    (lcmd),
        .cnt     (count_reg),
        .scale   (scale_reg),
        .half    (hw_reg),
        .obj     (st_ox_reg),
        .scene   (st_sx_reg),
        .busy    (busy_x),
        .res     (res_x)
    );

    rtsc_lane u_lane_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .lcmd    (lcmd),
        .cnt     (count_reg),
        .scale   (scale_reg),
        .half    (hh_reg),
        .obj     (st_oy_reg),
        .scene   (st_sy_reg),
        .busy    (busy_y),
        .res     (res_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            pos_x_reg      <= (count_reg == '0) ? '0 : res_x;
            pos_y_reg      <= (count_reg == '0) ? '0 : res_y;
            valid_res_reg  <= count_reg != '0;
            good_count_reg <= 9'(count_reg);
            overflow_reg   <= dropped_reg;
        end
    end

    assign st.last_in   = st_valid_reg && st_last_reg;
    assign st.n_zero    = count_reg == '0;
    assign st.n_small   = count_reg <= SMALL_N;
    assign st.lane_busy = busy_x || busy_y;
    assign st.scan_busy = scan_active_reg || v1_reg || v2_reg;
    assign st.out_busy  = m_valid_reg;

    assign m_valid      = m_valid_reg;
    assign m_pos_x      = pos_x_reg;
    assign m_pos_y      = pos_y_reg;
    assign m_valid_res  = valid_res_reg;
    assign m_good_count = good_count_reg;
    assign m_overflow   = overflow_reg;

endmodule

[hw/rtl/rtsc_ctrl.sv]
// ----------------------------------------------------------------------------
// rtsc_ctrl
// Sequencer: load phase, then mean, deviation pass, variance, root,
// clipping pass, clipped mean and result hand-off.
// ----------------------------------------------------------------------------
module rtsc_ctrl
    import rtsc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  ctrl_st_t  st,
    output ctrl_cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD: begin
                cmd.accept_en = !st.last_in;
                if (st.last_in) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (st.n_zero) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.mean_start = 1'b1;
                    state_next     = S_MEAN_WAIT;
                end
            end
            S_MEAN_WAIT: begin
                if (!st.lane_busy) begin
                    cmd.mean_cap = 1'b1;
                    state_next   = st.n_small ? S_FINISH : S_P1_START;
                end
            end
            S_P1_START: begin
                cmd.scan_start = 1'b1;
                state_next     = S_P1_WAIT;
            end
            S_P1_WAIT: begin
                if (!st.scan_busy) begin
                    cmd.var_start = 1'b1;
                    state_next    = S_VAR_WAIT;
                end
            end
            S_VAR_WAIT: begin
                if (!st.lane_busy) begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_SQRT_WAIT;
                end
            end
            S_SQRT_WAIT: begin
                if (!st.lane_busy) begin
                    state_next = S_P2_START;
                end
            end
            S_P2_START: begin
                cmd.scan_start = 1'b1;
                cmd.scan_p2    = 1'b1;
                state_next     = S_P2_WAIT;
            end
            S_P2_WAIT: begin
                if (!st.scan_busy) begin
                    cmd.res_start = 1'b1;
                    state_next    = S_RES_WAIT;
                end
            end
            S_RES_WAIT: begin
                if (!st.lane_busy) begin
                    cmd.res_cap = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!st.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule
